// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text glyph layout check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text glyph layout check failed");

`endif

// ===== design/tgl_pkg.sv =====
package tgl_pkg;

  // Special character codes
  localparam logic [7:0] CHAR_NL = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  // Glyph index divider: two quotient bits per step over an 8-bit code
  localparam int CODE_W        = 8;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS     = CODE_W / BITS_PER_STEP;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CHAR_SIZE      = 3'd0,
    REG_GLYPHS_PER_ROW = 3'd1,
    REG_SHADOW_DX      = 3'd2,
    REG_SHADOW_DY      = 3'd3,
    REG_TEXT_COLOR     = 3'd4,
    REG_SHADOW_COLOR   = 3'd5,
    REG_OUTLINE_COLOR  = 3'd6
  } cfg_reg_e;

  localparam int CFG_DATA_W = 24;

  // Configuration reset values
  localparam logic [6:0]  CHAR_SIZE_RST      = 7'd8;
  localparam logic [8:0]  GLYPHS_PER_ROW_RST = 9'd16;
  localparam logic [7:0]  SHADOW_DX_RST      = 8'd0;
  localparam logic [7:0]  SHADOW_DY_RST      = 8'd0;
  localparam logic [23:0] TEXT_COLOR_RST     = 24'hFFFFFF;
  localparam logic [23:0] SHADOW_COLOR_RST   = 24'h000000;
  localparam logic [23:0] OUTLINE_COLOR_RST  = 24'h000000;

  typedef struct packed {
    logic [7:0]         char_code;
    logic               first_of_string;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [14:0]        max_width;
    logic [14:0]        max_height;
  } char_beat_t;

  typedef struct packed {
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [13:0]        src_x;
    logic [13:0]        src_y;
    logic [23:0]        blit_color;
    logic               draw_outline;
    logic               last_of_char;
  } blit_beat_t;

  typedef struct packed {
    logic [2:0]            index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic newline;
    logic div_step;
    logic check;
    logic load;
    logic next_text;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stopped;
    logic is_nl;
    logic is_cr;
    logic past_width;
    logic shadow_en;
  } dp_status_t;

endpackage

// ===== design/tgl_stream_if.sv =====
interface tgl_stream_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/text_glyph_layout.sv =====
// Text layout: one character beat in, zero to two glyph blit beats out.
// Newline, carriage return and characters of a stopped string: no output.
// Drawn character: the glyph index divider runs first (two quotient bits a
// cycle), then the width check. A character past the width limit gives no blit;
// otherwise it gives one text blit, preceded by a shadow blit when shadow is on.
// Reset (rst_ni low, asynchronous) restores register defaults and clears the pen.
module text_glyph_layout (
  input  logic          clk_i,
  input  logic          rst_ni,
  tgl_stream_if.sink    in_i,
  tgl_stream_if.source  out_o,
  tgl_stream_if.sink    cfg_i
);

  tgl_pkg::ctrl_cmd_t  cmd;
  tgl_pkg::dp_status_t status;
  tgl_pkg::blit_beat_t out_beat;
  logic                in_ready;
  logic                out_valid;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_beat;

  tgl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tgl_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_beat_i  (cfg_i.data),
    .in_beat_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_beat_o  (out_beat)
  );

endmodule

// ===== design/tgl_ctrl.sv =====
module tgl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tgl_pkg::dp_status_t status_i,
  output tgl_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLASSIFY = 3'd1;
  localparam logic [2:0] S_DIV      = 3'd2;
  localparam logic [2:0] S_CHECK    = 3'd3;
  localparam logic [2:0] S_LOAD     = 3'd4;
  localparam logic [2:0] S_SHADOW   = 3'd5;
  localparam logic [2:0] S_TEXT     = 3'd6;

  localparam logic [tgl_pkg::DIV_CNT_W-1:0] CNT_LAST =
    tgl_pkg::DIV_CNT_W'(tgl_pkg::DIV_STEPS - 1);

  logic [2:0]                    state_q, state_d;
  logic [tgl_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        cnt_d = '0;
        if (status_i.stopped || status_i.is_cr) begin
          state_d = S_IDLE;
        end else if (status_i.is_nl) begin
          cmd_o.newline = 1'b1;
          state_d       = S_IDLE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.past_width ? S_IDLE : S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = status_i.shadow_en ? S_SHADOW : S_TEXT;
      end
      S_SHADOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.next_text = 1'b1;
          state_d         = S_TEXT;
        end
      end
      S_TEXT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== design/tgl_dpath.sv =====
module tgl_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  tgl_pkg::cfg_beat_t  cfg_beat_i,
  input  tgl_pkg::char_beat_t in_beat_i,
  input  tgl_pkg::ctrl_cmd_t  cmd_i,
  output tgl_pkg::dp_status_t status_o,
  output tgl_pkg::blit_beat_t out_beat_o
);

  // Configuration registers
  logic [6:0]  char_size_q;
  logic [8:0]  gpr_q;
  logic [7:0]  shadow_dx_q, shadow_dy_q;
  logic [23:0] text_color_q, shadow_color_q, outline_color_q;

  // Layout state
  logic [15:0] column_q, pen_y_q, pen_origin_x_q;
  logic [14:0] width_limit_q, height_limit_q;
  logic        stopped_q;

  // Per-character working registers
  logic [7:0]          code_q;
  logic [8:0]          rem_q, rem_d;
  logic [7:0]          quo_q, quo_d;
  logic [22:0]         off_q;
  logic [15:0]         x_q;
  tgl_pkg::blit_beat_t out_q;

  logic [8:0]  gpr_eff;
  logic [15:0] pen_y_nl;
  logic [15:0] x_d;
  logic [14:0] src_x_prod, src_y_prod;
  logic        shadow_en;
  logic        outline_en;

  assign gpr_eff    = (gpr_q == 9'd0) ? 9'd1 : gpr_q;
  assign pen_y_nl   = pen_y_q + {9'd0, char_size_q};
  assign shadow_en  = (shadow_dx_q != 8'd0) || (shadow_dy_q != 8'd0);
  assign outline_en = (outline_color_q != 24'd0);
  assign x_d        = pen_origin_x_q + off_q[15:0];
  assign src_x_prod = rem_q[7:0] * char_size_q;
  assign src_y_prod = quo_q * char_size_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_size_q     <= tgl_pkg::CHAR_SIZE_RST;
      gpr_q           <= tgl_pkg::GLYPHS_PER_ROW_RST;
      shadow_dx_q     <= tgl_pkg::SHADOW_DX_RST;
      shadow_dy_q     <= tgl_pkg::SHADOW_DY_RST;
      text_color_q    <= tgl_pkg::TEXT_COLOR_RST;
      shadow_color_q  <= tgl_pkg::SHADOW_COLOR_RST;
      outline_color_q <= tgl_pkg::OUTLINE_COLOR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_beat_i.index)
        tgl_pkg::REG_CHAR_SIZE:      char_size_q     <= cfg_beat_i.value[6:0];
        tgl_pkg::REG_GLYPHS_PER_ROW: gpr_q           <= cfg_beat_i.value[8:0];
        tgl_pkg::REG_SHADOW_DX:      shadow_dx_q     <= cfg_beat_i.value[7:0];
        tgl_pkg::REG_SHADOW_DY:      shadow_dy_q     <= cfg_beat_i.value[7:0];
        tgl_pkg::REG_TEXT_COLOR:     text_color_q    <= cfg_beat_i.value[23:0];
        tgl_pkg::REG_SHADOW_COLOR:   shadow_color_q  <= cfg_beat_i.value[23:0];
        tgl_pkg::REG_OUTLINE_COLOR:  outline_color_q <= cfg_beat_i.value[23:0];
        default: ;
      endcase
    end
  end

  // Layout state: string start, newline, column advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q       <= '0;
      pen_y_q        <= '0;
      pen_origin_x_q <= '0;
      width_limit_q  <= '0;
      height_limit_q <= '0;
      stopped_q      <= 1'b0;
    end else if (cmd_i.take) begin
      if (in_beat_i.first_of_string) begin
        pen_origin_x_q <= in_beat_i.origin_x;
        pen_y_q        <= in_beat_i.origin_y;
        width_limit_q  <= in_beat_i.max_width;
        height_limit_q <= in_beat_i.max_height;
        column_q       <= '0;
        stopped_q      <= 1'b0;
      end
    end else if (cmd_i.newline) begin
      pen_y_q  <= pen_y_nl;
      column_q <= '0;
      if ((height_limit_q != 15'd0) &&
          ($signed(pen_y_nl) > $signed({1'b0, height_limit_q}))) begin
        stopped_q <= 1'b1;
      end
    end else if (cmd_i.check) begin
      column_q <= column_q + 16'd1;
    end
  end

  // Restoring divide of the code by the atlas row length, two bits a step
  always_comb begin
    logic [10:0] diff;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < tgl_pkg::BITS_PER_STEP; i++) begin
      diff = {1'b0, rem_d, quo_d[7]} - {2'b00, gpr_eff};
      if (!diff[10]) begin
        rem_d = diff[8:0];
        quo_d = {quo_d[6:0], 1'b1};
      end else begin
        rem_d = {rem_d[7:0], quo_d[7]};
        quo_d = {quo_d[6:0], 1'b0};
      end
    end
  end

  // Working registers and the output beat
  always_ff @(posedge clk_i) begin
    off_q <= column_q * char_size_q;
    if (cmd_i.take) begin
      code_q <= in_beat_i.char_code;
      rem_q  <= '0;
      quo_q  <= in_beat_i.char_code;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.load) begin
      x_q         <= x_d;
      out_q.src_x <= src_x_prod[13:0];
      out_q.src_y <= src_y_prod[13:0];
      if (shadow_en) begin
        out_q.dest_x       <= x_d + {{8{shadow_dx_q[7]}}, shadow_dx_q};
        out_q.dest_y       <= pen_y_q + {{8{shadow_dy_q[7]}}, shadow_dy_q};
        out_q.blit_color   <= shadow_color_q;
        out_q.draw_outline <= 1'b0;
        out_q.last_of_char <= 1'b0;
      end else begin
        out_q.dest_x       <= x_d;
        out_q.dest_y       <= pen_y_q;
        out_q.blit_color   <= text_color_q;
        out_q.draw_outline <= outline_en;
        out_q.last_of_char <= 1'b1;
      end
    end else if (cmd_i.next_text) begin
      out_q.dest_x       <= x_q;
      out_q.dest_y       <= pen_y_q;
      out_q.blit_color   <= text_color_q;
      out_q.draw_outline <= outline_en;
      out_q.last_of_char <= 1'b1;
    end
  end

  // Status toward the controller
  always_comb begin
    status_o.stopped    = stopped_q;
    status_o.is_nl      = (code_q == tgl_pkg::CHAR_NL);
    status_o.is_cr      = (code_q == tgl_pkg::CHAR_CR);
    status_o.past_width = (width_limit_q != 15'd0) && (off_q > {8'd0, width_limit_q});
    status_o.shadow_en  = shadow_en;
  end

  assign out_beat_o = out_q;

endmodule

// ===== design/tgl_checker.sv =====
`include "assert_macros.svh"

module tgl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input tgl_pkg::blit_beat_t out_beat_i
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // A stalled blit holds its valid and payload
  `TGL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_beat_i))

  // One character at a time: no intake while a blit is offered
  `TGL_ASSERT_SAME(a_one_char, clk_i, rst_ni, out_valid_i, !in_ready_i)

  // No blit in the cycle right after a character beat
  `TGL_ASSERT_NEXT(a_no_early_blit, clk_i, rst_ni, in_beat, !out_valid_i)

  // A shadow blit is always followed by the text blit of the same character
  `TGL_ASSERT_NEXT(a_text_follows, clk_i, rst_ni, out_beat && !out_beat_i.last_of_char, out_valid_i && out_beat_i.last_of_char)

endmodule

bind text_glyph_layout tgl_checker u_tgl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.data)
);
